// ===== rtl/cesc_pkg.sv =====
// shared types and constants for the c escape decoder
`timescale 1ns / 1ps
package cesc_pkg;

    localparam int CodeW = 32;
    localparam int StatusW = 2;

    // decoder phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_HEX  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_END    = 2'd1;
    localparam logic [1:0] ST_BADHEX = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    // register byte addresses
    localparam logic [2:0] ADDR_WIDE_CHARS = 3'd0;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_UU    = 8'h55;

    localparam logic [CodeW-1:0] MAX_NARROW = 32'h0000_00FF;

    typedef struct packed {
        logic [1:0]       phase;
        logic [3:0]       digits_left;
        logic [CodeW-1:0] accumulator;
    } t_state;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [CodeW-1:0]   code_point;
    } t_result;

endpackage

// ===== rtl/cesc_step.sv =====
// next-state and result logic for one input byte
`timescale 1ns / 1ps
module cesc_step (
    input  cesc_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_wide,
    output cesc_pkg::t_state  o_state,
    output logic              o_emit,
    output cesc_pkg::t_result o_result
);
    import cesc_pkg::*;

    logic       hex_ok;
    logic [3:0] hex_val;
    logic [3:0] dl_dec;
    logic [CodeW-1:0] acc_shift;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_val = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            hex_val = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign dl_dec    = i_state.digits_left - 4'd1;
    assign acc_shift = {i_state.accumulator[CodeW-5:0], hex_val};

    always_comb begin
        o_state           = i_state;
        o_emit            = 1'b0;
        o_result.status   = ST_OK;
        o_result.code_point = {{(CodeW-8){1'b0}}, i_byte};
        case (i_state.phase)
            PH_ESC: begin
                o_emit        = 1'b1;
                o_state.phase = PH_IDLE;
                case (i_byte)
                    CH_NUL: begin
                        o_result.status     = ST_END;
                        o_result.code_point = '0;
                    end
                    CH_A: o_result.code_point = 32'h07;
                    CH_B: o_result.code_point = 32'h08;
                    CH_F: o_result.code_point = 32'h0C;
                    CH_N: o_result.code_point = 32'h0A;
                    CH_R: o_result.code_point = 32'h0D;
                    CH_T: o_result.code_point = 32'h09;
                    CH_V: o_result.code_point = 32'h0B;
                    CH_X, CH_LU, CH_UU: begin
                        o_emit              = 1'b0;
                        o_state.phase       = PH_HEX;
                        o_state.accumulator = '0;
                        o_state.digits_left = (i_byte == CH_X)  ? 4'd2 :
                                              (i_byte == CH_LU) ? 4'd4 : 4'd8;
                    end
                    default: ;
                endcase
            end
            PH_HEX: begin
                if (!hex_ok) begin
                    o_emit              = 1'b1;
                    o_state.phase       = PH_IDLE;
                    o_state.accumulator = '0;
                    o_state.digits_left = 4'd0;
                    o_result.status     = ST_BADHEX;
                    o_result.code_point = '0;
                end else begin
                    o_state.accumulator = acc_shift;
                    o_state.digits_left = dl_dec;
                    if (dl_dec == 4'd0 || dl_dec > 4'd8) begin
                        // last digit: range check against the current mode
                        o_emit              = 1'b1;
                        o_state.phase       = PH_IDLE;
                        o_state.digits_left = 4'd0;
                        if (!i_wide && acc_shift > MAX_NARROW) begin
                            o_result.status     = ST_RANGE;
                            o_result.code_point = '0;
                        end else begin
                            o_result.code_point = acc_shift;
                        end
                    end
                end
            end
            default: begin
                // idle, and the unused phase code
                if (i_byte == CH_BSL) begin
                    o_state.phase = PH_ESC;
                end else begin
                    o_emit        = 1'b1;
                    o_state.phase = PH_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== rtl/cesc_outbuf.sv =====
// two-entry output buffer: result register plus skid stage
`timescale 1ns / 1ps
module cesc_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cesc_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_taken,
    output cesc_pkg::t_result o_data
);
    import cesc_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_taken;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== rtl/c_escape_decoder.sv =====
// c escape decoder top level: config register, decoder state, output buffer
// output: each result beat is registered in the result register or skid stage
// throughput: one byte per cycle while the skid stage is empty; a two-entry
// output buffer keeps input open while one result waits downstream
// reset: synchronous active-low, clears phase, digit count, accumulator,
// wide_chars and the output buffer
`timescale 1ns / 1ps
module c_escape_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] code_point
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import cesc_pkg::*;

    logic    r_wide;
    t_state  r_state;
    t_state  n_state;
    logic    step_emit;
    t_result step_result;
    t_result out_data;
    logic    in_beat;

    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_WIDE_CHARS) ? {31'd0, r_wide} : 32'd0;
    assign in_beat = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b0;
        end else if (psel && penable && pwrite && paddr == ADDR_WIDE_CHARS) begin
            r_wide <= pwdata[0];
        end
    end

    cesc_step u_step (
        .i_state  (r_state),
        .i_byte   (s_axis_tdata),
        .i_wide   (r_wide),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    cesc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_beat && step_emit),
        .i_data  (step_result),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_taken (m_axis_tready),
        .o_data  (out_data)
    );

    assign m_axis_tdata = out_data.code_point;
    assign m_axis_tuser = out_data.status;

endmodule

// ===== tb/c_escape_decoder_checker.sv =====
// checker for the c escape decoder: predicts each result beat and compares it
`timescale 1ns / 1ps
module c_escape_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] code_point
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    output int          o_mismatches,
    output int          o_pending
);
    import cesc_pkg::*;

    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_F = 8'h46;

    logic             wide_mode;
    logic [1:0]       dec_phase;
    logic [3:0]       digits_due;
    logic [CodeW-1:0] hex_acc;
    int               fail_total;
    t_result          pending_chars[$];

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= DIGIT_0 && b <= DIGIT_9) return int'(b - DIGIT_0);
        if (b >= CH_A && b <= CH_F) return int'(b - CH_A) + 10;
        if (b >= UPPER_A && b <= UPPER_F) return int'(b - UPPER_A) + 10;
        return -1;
    endfunction

    // advances the decoder by one byte; returns 1 when a result comes out
    function automatic bit decode_byte(input logic [7:0] b, output t_result r);
        int d;
        bit has;
        r   = '0;
        has = 1'b0;
        case (dec_phase)
            PH_ESC: begin
                dec_phase = PH_IDLE;
                has = 1'b1;
                case (b)
                    CH_NUL: r.status = ST_END;
                    CH_A:   r.code_point = 32'h07;
                    CH_B:   r.code_point = 32'h08;
                    CH_F:   r.code_point = 32'h0C;
                    CH_N:   r.code_point = 32'h0A;
                    CH_R:   r.code_point = 32'h0D;
                    CH_T:   r.code_point = 32'h09;
                    CH_V:   r.code_point = 32'h0B;
                    CH_X, CH_LU, CH_UU: begin
                        has = 1'b0;
                        hex_acc = '0;
                        dec_phase = PH_HEX;
                        digits_due = (b == CH_X) ? 4'd2 : (b == CH_LU) ? 4'd4 : 4'd8;
                    end
                    default: r.code_point = CodeW'(b);
                endcase
            end
            PH_HEX: begin
                d = hex_digit(b);
                if (d < 0) begin
                    // collected digits are thrown away
                    hex_acc = '0;
                    digits_due = '0;
                    dec_phase = PH_IDLE;
                    has = 1'b1;
                    r.status = ST_BADHEX;
                end else begin
                    hex_acc = {hex_acc[CodeW-5:0], d[3:0]};
                    digits_due = digits_due - 4'd1;
                    if (digits_due == 4'd0) begin
                        dec_phase = PH_IDLE;
                        has = 1'b1;
                        // range is judged with the mode in force at the last digit
                        if (!wide_mode && hex_acc > MAX_NARROW) r.status = ST_RANGE;
                        else r.code_point = hex_acc;
                    end
                end
            end
            default: begin
                if (b == CH_BSL) begin
                    dec_phase = PH_ESC;
                end else begin
                    has = 1'b1;
                    r.code_point = CodeW'(b);
                end
            end
        endcase
        return has;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            wide_mode  = 1'b0;
            dec_phase  = PH_IDLE;
            digits_due = '0;
            hex_acc    = '0;
            fail_total = 0;
            pending_chars.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.code_point = m_axis_tdata;
                got.status     = m_axis_tuser;
                if (pending_chars.size() == 0) begin
                    $display("%0t: result beat with nothing expected, code_point %h status %0d",
                             $time, got.code_point, got.status);
                    fail_total++;
                end else begin
                    want = pending_chars.pop_front();
                    if (got.code_point !== want.code_point) begin
                        $display("%0t: code_point expected %h actual %h",
                                 $time, want.code_point, got.code_point);
                        fail_total++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fail_total++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (decode_byte(s_axis_tdata, want)) pending_chars.push_back(want);
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_WIDE_CHARS)
                wide_mode = pwdata[0];
        end
        o_pending    <= pending_chars.size();
        o_mismatches <= fail_total;
    end

endmodule

// ===== tb/c_escape_decoder_tb.sv =====
// testbench top for the c escape decoder: stimulus, stalls and verdict
`timescale 1ns / 1ps
module c_escape_decoder_tb;
    import cesc_pkg::*;

    localparam int         RANDOM_BYTES = 500;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [2:0] ADDR_SPARE   = 3'd4;
    localparam logic [7:0] DIGIT_0      = 8'h30;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] CH_G         = 8'h67;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] code_point
    logic [1:0]  m_axis_tuser;     // [1:0] status

    int mismatches;
    int pending;
    int bytes_sent;
    int cycle_count;
    bit quiet;

    c_escape_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    c_escape_decoder_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10) return DIGIT_0 + 8'(v);
        return (upper ? UPPER_A : CH_A) + 8'(v - 10);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every expected beat has come out, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_hex_escape();
        int sel;
        int ndig;
        int bad_at;
        int v;
        bit lead;
        logic [7:0] junk;
        sel    = $urandom_range(0, 2);
        ndig   = (sel == 0) ? 2 : (sel == 1) ? 4 : 8;
        lead   = 1'($urandom_range(0, 1));
        bad_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, ndig - 1) : ndig;
        send_byte(CH_BSL);
        send_byte((sel == 0) ? CH_X : (sel == 1) ? CH_LU : CH_UU);
        for (int i = 0; i < ndig; i++) begin
            if (i == bad_at) begin
                junk = 8'($urandom_range(0, 255));
                if ((junk >= DIGIT_0 && junk < DIGIT_0 + 8'd10) ||
                    (junk >= UPPER_A && junk < UPPER_A + 8'd6) ||
                    (junk >= CH_A && junk < CH_A + 8'd6))
                    junk = CH_G;
                send_byte(junk);
                break;
            end
            // leading zeros keep many values inside the narrow range
            v = (lead && i < ndig - 2) ? 0 : $urandom_range(0, 15);
            send_byte(hex_char(v, 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic send_token();
        int r;
        logic [7:0] esc;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (r < 45) begin
            case ($urandom_range(0, 9))
                0: esc = CH_A;
                1: esc = CH_B;
                2: esc = CH_F;
                3: esc = CH_N;
                4: esc = CH_R;
                5: esc = CH_T;
                6: esc = CH_V;
                7: esc = CH_BSL;
                8: esc = CH_QUOTE;
                default: esc = CH_DQUOTE;
            endcase
            send_byte(CH_BSL);
            send_byte(esc);
        end else if (r < 55) begin
            send_byte(CH_BSL);
            send_byte(8'($urandom_range(0, 255)));
        end else if (r < 90) begin
            send_hex_escape();
        end else begin
            send_byte(CH_BSL);
            send_byte(CH_NUL);
        end
    endtask

    // sink side: ready bursts broken by random stalls
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            if (gap_len() > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [31:0] wval;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        cycle_count   = 0;
        bytes_sent    = 0;
        quiet         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: narrow mode
        write_reg(ADDR_WIDE_CHARS, 32'd0);
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_byte(CH_BSL);
        send_byte(CH_N);
        send_byte(CH_BSL);
        send_byte(CH_NUL);
        send_byte(CH_BSL);
        send_byte(CH_X);
        send_byte(hex_char(15, 1));
        send_byte(hex_char(15, 0));
        // just above the narrow range
        send_byte(CH_BSL);
        send_byte(CH_LU);
        send_byte(hex_char(0, 0));
        send_byte(hex_char(1, 0));
        send_byte(hex_char(0, 0));
        send_byte(hex_char(0, 0));
        wait_drained();

        // directed: wide mode, full eight digits and a bad digit
        write_reg(ADDR_WIDE_CHARS, 32'd1);
        send_byte(CH_BSL);
        send_byte(CH_UU);
        for (int i = 0; i < 6; i++) send_byte(hex_char(10 + i, i[0]));
        send_byte(hex_char(0, 0));
        send_byte(hex_char(9, 0));
        send_byte(CH_BSL);
        send_byte(CH_X);
        send_byte(CH_G);

        while (bytes_sent < RANDOM_BYTES + 30) begin
            wait_drained();
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) write_reg(ADDR_SPARE, $urandom);
            wval    = $urandom;
            wval[0] = 1'($urandom_range(0, 1));
            write_reg(ADDR_WIDE_CHARS, wval);
            repeat ($urandom_range(5, 20)) send_token();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== c_escape_decoder.f =====
rtl/cesc_pkg.sv
rtl/cesc_step.sv
rtl/cesc_outbuf.sv
rtl/c_escape_decoder.sv
tb/c_escape_decoder_checker.sv
tb/c_escape_decoder_tb.sv
